/* src/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg - shared definitions for the pattern deletion stack
// Sizes, operation and register codes, and the pattern byte selector.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int STACK_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 13;
    localparam int MAX_PATTERN = 16;
    localparam int PLEN_W      = 5;
    localparam int PIDX_W      = $clog2(MAX_PATTERN);
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 12;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(STACK_DEPTH);
    localparam logic [PLEN_W-1:0] MAX_PAT_LEN = PLEN_W'(MAX_PATTERN);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd2;

    // byte idx of the 16-byte pattern, byte 0 in the low bits of lo
    function automatic logic [CHAR_W-1:0] pat_byte(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [PIDX_W-1:0]     idx
    );
        logic [2*CFG_DATA_W-1:0] w;
        w = {hi, lo};
        return w[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

/* src/pds_ram.sv */
// ----------------------------------------------------------------------------
// pds_ram - generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/pattern_deletion_stack_core.sv */
// ----------------------------------------------------------------------------
// pattern_deletion_stack_core - byte stack with configured pattern removal
// Flow: a clear, an unused code, a push with no stack walk or an out-of-range read goes
//   straight to S_DONE; an in-range read passes S_READ, a screened push walks S_CMP first.
// Beats: one at a time, taken the cycle after its result is registered, as S_DONE
//   waits while the output register is full; the RAM walk reads a byte a cycle.
// Reset: synchronous active low; clears count, sequencer, valid; length 1, bytes 0.
// ----------------------------------------------------------------------------
module pattern_deletion_stack_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [pds_pkg::IN_DATA_W-1:0]    i_s_tdata,  // [7:0] char_in, [19:8] read_index
    input  logic [pds_pkg::OP_W-1:0]         i_s_tuser,  // [1:0] op
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [pds_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // [12:0] kept_length, [13] removed,
                                                         // [21:14] read_char, [22] fault
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pds_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;  // walk stored pattern bytes
    localparam logic [1:0] S_READ = 2'd2;  // wait for RAM read data
    localparam logic [1:0] S_DONE = 2'd3;  // hand result to output register

    logic [1:0]                        r_state, n_state;
    logic [pds_pkg::CNT_W-1:0]         r_count, n_count;
    logic [pds_pkg::PIDX_W-1:0]        r_k, n_k;
    logic [pds_pkg::ADDR_W-1:0]        r_base, n_base;
    logic [pds_pkg::PLEN_W-1:0]        r_len, n_len;
    logic                              r_removed, n_removed;
    logic [pds_pkg::CHAR_W-1:0]        r_char, n_char;
    logic                              r_fault, n_fault;
    logic                              r_out_vld, n_out_vld;
    logic [pds_pkg::OUT_DATA_W-1:0]    r_out_data, n_out_data;

    logic [pds_pkg::PLEN_W-1:0]        r_pat_len;
    logic [pds_pkg::CFG_DATA_W-1:0]    r_pat_lo;
    logic [pds_pkg::CFG_DATA_W-1:0]    r_pat_hi;

    // input beat fields
    logic                              s_accept;
    logic [pds_pkg::OP_W-1:0]          in_op;
    logic [pds_pkg::CHAR_W-1:0]        in_char;
    logic [pds_pkg::IDX_W-1:0]         in_idx;

    // RAM interface
    logic                              ram_wr_en;
    logic [pds_pkg::ADDR_W-1:0]        ram_rd_addr;
    logic [pds_pkg::CHAR_W-1:0]        ram_rd_data;

    // push helpers
    logic [pds_pkg::PLEN_W-1:0]        eff_len;
    logic [pds_pkg::CNT_W-1:0]         push_count;
    logic [pds_pkg::CNT_W-1:0]         push_base;
    logic [pds_pkg::CHAR_W-1:0]        last_pat;
    logic [pds_pkg::CHAR_W-1:0]        cmp_pat;

    assign in_op   = i_s_tuser;
    assign in_char = i_s_tdata[pds_pkg::CHAR_W-1:0];
    assign in_idx  = i_s_tdata[pds_pkg::CHAR_W +: pds_pkg::IDX_W];

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    // Clamp the configured length to the pattern store size.
    assign eff_len    = (r_pat_len > pds_pkg::MAX_PAT_LEN) ? pds_pkg::MAX_PAT_LEN : r_pat_len;
    assign push_count = r_count + pds_pkg::CNT_W'(1);
    assign push_base  = push_count - pds_pkg::CNT_W'(eff_len);
    assign last_pat   = pds_pkg::pat_byte(r_pat_lo, r_pat_hi,
                                          pds_pkg::PIDX_W'(eff_len - pds_pkg::PLEN_W'(1)));
    assign cmp_pat    = pds_pkg::pat_byte(r_pat_lo, r_pat_hi, r_k - pds_pkg::PIDX_W'(1));

    // Write the pushed byte on accept when there is room.
    assign ram_wr_en = s_accept && (in_op == pds_pkg::OP_PUSH) && (r_count < pds_pkg::DEPTH_CNT);

    // Read address: the read index on accept, else the next stored pattern slot.
    always_comb begin
        if (r_state == S_IDLE) begin
            ram_rd_addr = in_idx[pds_pkg::ADDR_W-1:0];
        end else begin
            ram_rd_addr = r_base + pds_pkg::ADDR_W'(r_k);
        end
    end

    pds_ram #(
        .WIDTH (pds_pkg::CHAR_W),
        .DEPTH (pds_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[pds_pkg::ADDR_W-1:0]),
        .i_wr_data (in_char),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_base     = r_base;
        n_len      = r_len;
        n_removed  = r_removed;
        n_char     = r_char;
        n_fault    = r_fault;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;

        // drop the held result once the sink takes it
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_removed = 1'b0;
                    n_char    = '0;
                    n_fault   = 1'b0;
                    n_state   = S_DONE;
                    unique if (in_op == pds_pkg::OP_PUSH) begin
                        if (r_count >= pds_pkg::DEPTH_CNT) begin
                            n_fault = 1'b1;
                        end else begin
                            n_count = push_count;
                            // Screen with the new byte against the last pattern
                            // byte; walk the RAM only when it agrees.
                            if ((eff_len != '0) &&
                                (push_count >= pds_pkg::CNT_W'(eff_len)) &&
                                (in_char == last_pat)) begin
                                n_k     = '0;
                                n_base  = push_base[pds_pkg::ADDR_W-1:0];
                                n_len   = eff_len;
                                n_state = S_CMP;
                            end
                        end
                    end else if (in_op == pds_pkg::OP_READ) begin
                        if (pds_pkg::CNT_W'(in_idx) < r_count) begin
                            n_state = S_READ;
                        end else begin
                            n_fault = 1'b1;
                        end
                    end else if (in_op == pds_pkg::OP_CLEAR) begin
                        n_count = '0;
                    end else begin
                        n_count = r_count;
                    end
                end
            end

            S_CMP: begin
                // Cycle k issues slot k and checks the data of slot k-1.
                if ((r_k != '0) && (ram_rd_data != cmp_pat)) begin
                    n_state = S_DONE;
                end else if (pds_pkg::PLEN_W'(r_k) == r_len - pds_pkg::PLEN_W'(1)) begin
                    n_count   = r_count - pds_pkg::CNT_W'(r_len);
                    n_removed = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_k = r_k + pds_pkg::PIDX_W'(1);
                end
            end

            S_READ: begin
                n_char  = ram_rd_data;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {1'b0, r_fault, r_char, r_removed, r_count};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_base     <= n_base;
        r_len      <= n_len;
        r_removed  <= n_removed;
        r_char     <= n_char;
        r_fault    <= n_fault;
        r_out_data <= n_out_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= pds_pkg::PLEN_W'(1);
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pds_pkg::REG_PAT_LEN:  r_pat_len <= i_cfg_data[pds_pkg::PLEN_W-1:0];
                pds_pkg::REG_PAT_LOW:  r_pat_lo  <= i_cfg_data;
                pds_pkg::REG_PAT_HIGH: r_pat_hi  <= i_cfg_data;
                default: begin
                    r_pat_len <= r_pat_len;
                end
            endcase
        end
    end

endmodule

/* tb/pds_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pds_checker - result checker for the pattern deletion stack
// Watches the configuration, input and result channels, predicts the result
// of every accepted input beat and compares it field by field in order.
// ----------------------------------------------------------------------------
module pds_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [pds_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic [pds_pkg::OP_W-1:0]          i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [pds_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [pds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_removals
);

    // laid out as the result tdata, kept_length in the low bits
    typedef struct packed {
        logic                       fault;
        logic [pds_pkg::CHAR_W-1:0] read_char;
        logic                       removed;
        logic [pds_pkg::CNT_W-1:0]  kept_length;
    } t_stack_result;

    logic [pds_pkg::CHAR_W-1:0]       stack_mem [pds_pkg::STACK_DEPTH];
    int unsigned                      kept_cnt     = 0;
    logic [pds_pkg::PLEN_W-1:0]       pat_len      = pds_pkg::PLEN_W'(1);
    logic [2*pds_pkg::CFG_DATA_W-1:0] pat_bytes    = '0;  // pattern byte k at bits 8k+7..8k
    t_stack_result                    result_q[$];
    int                               fail_cnt     = 0;
    int                               checked_cnt  = 0;
    int                               removal_cnt  = 0;

    // Apply one beat to the shadow stack and return the result it should give.
    function automatic t_stack_result apply_beat(
        input logic [pds_pkg::OP_W-1:0]   op,
        input logic [pds_pkg::CHAR_W-1:0] ch,
        input logic [pds_pkg::IDX_W-1:0]  idx
    );
        t_stack_result r;
        int unsigned   span;
        logic          hit;
        r = '0;
        case (op)
            pds_pkg::OP_PUSH: begin
                if (kept_cnt >= pds_pkg::STACK_DEPTH) begin
                    r.fault = 1'b1;  // full: drop the byte, no compare
                end else begin
                    stack_mem[kept_cnt] = ch;
                    kept_cnt++;
                    span = (pat_len > pds_pkg::MAX_PATTERN) ? pds_pkg::MAX_PATTERN : pat_len;
                    hit  = (span != 0) && (kept_cnt >= span);
                    if (hit) begin
                        for (int k = 0; k < span; k++) begin
                            if (stack_mem[kept_cnt - span + k] !=
                                pat_bytes[k*pds_pkg::CHAR_W +: pds_pkg::CHAR_W])
                                hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        kept_cnt -= span;
                        r.removed = 1'b1;
                    end
                end
            end
            pds_pkg::OP_READ: begin
                if (idx < kept_cnt)
                    r.read_char = stack_mem[idx];
                else
                    r.fault = 1'b1;
            end
            pds_pkg::OP_CLEAR: kept_cnt = 0;
            default: ;  // unused code leaves the stack alone
        endcase
        r.kept_length = pds_pkg::CNT_W'(kept_cnt);
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_stack_result want;
        t_stack_result got;
        if (!i_rst_n) begin
            kept_cnt  = 0;
            pat_len   = pds_pkg::PLEN_W'(1);
            pat_bytes = '0;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pds_pkg::REG_PAT_LEN:  pat_len = i_cfg_data[pds_pkg::PLEN_W-1:0];
                    pds_pkg::REG_PAT_LOW:  pat_bytes[pds_pkg::CFG_DATA_W-1:0] = i_cfg_data;
                    pds_pkg::REG_PAT_HIGH:
                        pat_bytes[2*pds_pkg::CFG_DATA_W-1:pds_pkg::CFG_DATA_W] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                result_q = {result_q,
                            apply_beat(i_s_tuser, i_s_tdata[pds_pkg::CHAR_W-1:0],
                                       i_s_tdata[pds_pkg::CHAR_W +: pds_pkg::IDX_W])};
            if (i_m_tvalid && i_m_tready) begin
                got = t_stack_result'(i_m_tdata[$bits(t_stack_result)-1:0]);
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with none expected, actual %0h", $time, got);
                    fail_cnt++;
                end else begin
                    want = result_q.pop_front();
                    checked_cnt++;
                    if (want.removed)
                        removal_cnt++;
                    if (got.kept_length !== want.kept_length)
                        report_field("kept_length", 32'(want.kept_length),
                                     32'(got.kept_length));
                    if (got.removed !== want.removed)
                        report_field("removed", 32'(want.removed), 32'(got.removed));
                    if (got.read_char !== want.read_char)
                        report_field("read_char", 32'(want.read_char), 32'(got.read_char));
                    if (got.fault !== want.fault)
                        report_field("fault", 32'(want.fault), 32'(got.fault));
                end
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
        o_removals   <= removal_cnt;
    end

endmodule

/* tb/pattern_deletion_stack_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pattern_deletion_stack_core_tb - stimulus and verdict for the deletion stack
// Drives directed corner beats, a full-stack fill and random phases of nested
// pattern sequences under varying idle and stall mixes; pds_checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module pattern_deletion_stack_core_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int PHASE_BEATS  = 210;   // least random beats queued per phase
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 40;    // longest push latency with margin
    localparam logic [pds_pkg::OP_W-1:0] OP_NONE = 2'd3;  // unused code; leaves the stack alone

    typedef struct {
        logic [pds_pkg::OP_W-1:0]   op;
        logic [pds_pkg::CHAR_W-1:0] ch;
        logic [pds_pkg::IDX_W-1:0]  idx;
    } t_stack_beat;

    // clock, reset and block ports
    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [pds_pkg::IN_DATA_W-1:0]      s_tdata   = '0;
    logic [pds_pkg::OP_W-1:0]           s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [pds_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [pds_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pds_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    // checker feedback
    int fail_count;
    int pending;
    int checked;
    int removals;

    // stimulus state
    t_stack_beat                beat_q[$];
    logic [pds_pkg::CHAR_W-1:0] gen_pat [pds_pkg::MAX_PATTERN];  // current pattern bytes
    int                         gen_len       = 1;      // effective pattern length
    int                         send_idle_pct = 0;
    int                         stall_pct     = 0;
    bit                         hold_token    = 1'b0;   // toggle to start a hold-off
    bit                         hold_seen     = 1'b0;
    int                         hold_left     = 0;
    int                         beats_sent    = 0;
    int                         cycle_cnt     = 0;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    pattern_deletion_stack_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),    // [7:0] char_in, [19:8] read_index, [23:20] zero
        .i_s_tuser   (s_tuser),    // [1:0] op
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),    // [12:0] kept_length, [13] removed,
                                   // [21:14] read_char, [22] fault
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pds_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_removals   (removals)
    );

    // Result side: a hold-off request wins and is counted down here; otherwise
    // stall at random per the current percentage.
    always @(posedge clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_cnt, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one beat, after a random gap, and hold it until accepted. Valid
    // stays high on return so back-to-back beats keep it asserted.
    task automatic send_beat(input t_stack_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pds_pkg::IN_DATA_W-pds_pkg::IDX_W-pds_pkg::CHAR_W){1'b0}}, b.idx, b.ch};
        s_tuser  <= b.op;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_all();
        while (beat_q.size() != 0)
            send_beat(beat_q.pop_front());
        s_tvalid <= 1'b0;
    endtask

    // Advance until no result is outstanding.
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [pds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pds_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Program all three registers and mirror the pattern for the generators.
    task automatic set_pattern(input logic [pds_pkg::PLEN_W-1:0] len,
                               input logic [pds_pkg::CFG_DATA_W-1:0] lo,
                               input logic [pds_pkg::CFG_DATA_W-1:0] hi);
        logic [2*pds_pkg::CFG_DATA_W-1:0] pat_all;
        cfg_write(pds_pkg::REG_PAT_LEN, pds_pkg::CFG_DATA_W'(len));
        cfg_write(pds_pkg::REG_PAT_LOW, lo);
        cfg_write(pds_pkg::REG_PAT_HIGH, hi);
        cfg_valid <= 1'b0;
        pat_all = {hi, lo};
        gen_len = (len > pds_pkg::MAX_PATTERN) ? pds_pkg::MAX_PATTERN : len;
        for (int k = 0; k < pds_pkg::MAX_PATTERN; k++)
            gen_pat[k] = pat_all[k*pds_pkg::CHAR_W +: pds_pkg::CHAR_W];
    endtask

    task automatic queue_beat(input logic [pds_pkg::OP_W-1:0] op,
                              input logic [pds_pkg::CHAR_W-1:0] ch,
                              input logic [pds_pkg::IDX_W-1:0] idx);
        t_stack_beat b;
        b.op  = op;
        b.ch  = ch;
        b.idx = idx;
        beat_q = {beat_q, b};
    endtask

    task automatic queue_push(input logic [pds_pkg::CHAR_W-1:0] ch);
        queue_beat(pds_pkg::OP_PUSH, ch, pds_pkg::IDX_W'($urandom));
    endtask

    // One full pattern, sometimes with another pattern nested inside it so
    // the inner removal reassembles the outer one; rarely broken by a stray byte.
    task automatic queue_pattern(input int depth);
        int n;
        n = (gen_len == 0) ? 1 + $urandom_range(pds_pkg::MAX_PATTERN - 1) : gen_len;
        for (int k = 0; k < n; k++) begin
            if (depth > 0 && $urandom_range(3) == 0)
                queue_pattern(depth - 1);
            else if ($urandom_range(24) == 0)
                queue_push(pds_pkg::CHAR_W'($urandom));
            queue_push(gen_pat[k]);
        end
    endtask

    // Bytes drawn from a four-letter alphabet, so patterns overlap themselves.
    function automatic logic [pds_pkg::CFG_DATA_W-1:0] alpha_word();
        logic [pds_pkg::CFG_DATA_W-1:0] w;
        for (int k = 0; k < pds_pkg::CFG_DATA_W / pds_pkg::CHAR_W; k++)
            w[k*pds_pkg::CHAR_W +: pds_pkg::CHAR_W] =
                8'h61 + pds_pkg::CHAR_W'($urandom_range(3));
        return w;
    endfunction

    initial begin
        int pick;
        int cut;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset pattern is a single 0x00 byte.
        queue_push(8'h00);                     // removed at once
        queue_push(8'hFF);
        queue_push(8'h80);
        queue_beat(pds_pkg::OP_READ, 8'hFF, 12'd0);
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'd1);
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'd2);     // at kept length: fault
        queue_beat(pds_pkg::OP_READ, 8'hFF, 12'hFFF);   // far past: fault
        queue_beat(OP_NONE, 8'hFF, 12'hFFF);            // unused code
        queue_beat(pds_pkg::OP_CLEAR, 8'hAA, 12'h555);
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'd0);     // empty stack: fault
        send_all();
        wait_drained();

        // Directed: longest pattern, all distinct bytes, removed on the last push.
        set_pattern(pds_pkg::MAX_PAT_LEN, 64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9988);
        for (int k = 0; k < pds_pkg::MAX_PATTERN; k++)
            queue_push(gen_pat[k]);
        send_all();
        wait_drained();

        // Fill the stack with removal disabled, then push into it while full.
        set_pattern('0, {$urandom, $urandom}, {$urandom, $urandom});
        repeat (pds_pkg::STACK_DEPTH)
            queue_push(pds_pkg::CHAR_W'($urandom));
        queue_push(8'h00);                     // dropped
        queue_push(8'hFF);                     // dropped
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'hFFF);   // topmost entry
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'd0);
        queue_beat(pds_pkg::OP_READ, 8'h00, pds_pkg::IDX_W'($urandom));
        send_all();
        wait_drained();
        // A full stack drops even a byte that would complete the pattern.
        set_pattern(pds_pkg::PLEN_W'(1), 64'h5A, '0);
        queue_push(8'h5A);
        queue_beat(pds_pkg::OP_CLEAR, 8'h00, 12'd0);
        queue_beat(pds_pkg::OP_READ, 8'h00, 12'd0);
        send_all();

        // Random phases: each starts once every result is back, reprograms the
        // pattern and picks an idle and stall mix.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: set_pattern(pds_pkg::PLEN_W'(1), {$urandom, $urandom},
                               {$urandom, $urandom});
                1: set_pattern(pds_pkg::MAX_PAT_LEN, '1, '1);
                2: set_pattern('0, {$urandom, $urandom}, {$urandom, $urandom});
                3: set_pattern('1, alpha_word(), alpha_word());        // acts as 16
                4: set_pattern(pds_pkg::PLEN_W'(2), alpha_word(), alpha_word());
                5: set_pattern(pds_pkg::PLEN_W'(pds_pkg::MAX_PATTERN + 1), '0, '0);
                6: set_pattern(pds_pkg::PLEN_W'(1 + $urandom_range(7)),
                               {$urandom, $urandom}, {$urandom, $urandom});
                default: set_pattern(pds_pkg::PLEN_W'($urandom_range(31)),
                                     alpha_word(), alpha_word());
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 79; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 79; end
                default: begin send_idle_pct = 35; stall_pct <= 35; end
            endcase
            // Hold the result side off for a long stretch while beats keep coming.
            if (p == 4)
                hold_token <= ~hold_token;

            while (beat_q.size() < PHASE_BEATS) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    queue_pattern(2);
                end else if (pick < 64) begin
                    queue_push($urandom_range(1)
                               ? gen_pat[$urandom_range(pds_pkg::MAX_PATTERN - 1)]
                               : pds_pkg::CHAR_W'($urandom));
                end else if (pick < 84) begin
                    queue_beat(pds_pkg::OP_READ, pds_pkg::CHAR_W'($urandom),
                               ($urandom_range(3) == 0) ? pds_pkg::IDX_W'($urandom)
                                                        : pds_pkg::IDX_W'($urandom_range(31)));
                end else if (pick < 90) begin
                    queue_beat(pds_pkg::OP_CLEAR, pds_pkg::CHAR_W'($urandom),
                               pds_pkg::IDX_W'($urandom));
                end else if (pick < 94) begin
                    queue_beat(OP_NONE, pds_pkg::CHAR_W'($urandom), pds_pkg::IDX_W'($urandom));
                end else begin
                    // broken sequence: a pattern prefix cut short by a random byte
                    cut = $urandom_range((gen_len == 0) ? pds_pkg::MAX_PATTERN - 1
                                                        : gen_len - 1);
                    for (int k = 0; k < cut; k++)
                        queue_push(gen_pat[k]);
                    queue_push(pds_pkg::CHAR_W'($urandom));
                end
            end
            send_all();
        end

        // Drain, then give any stray result time to show up.
        wait_drained();
        stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d beats: directed corners, a full-stack fill and %0d random phases",
                 beats_sent, NUM_PHASES);
        $display("under all idle/stall mixes; %0d results checked, %0d pattern removals",
                 checked, removals);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* pattern_deletion_stack_core.f */
src/pds_pkg.sv
src/pds_ram.sv
src/pattern_deletion_stack_core.sv
tb/pds_checker.sv
tb/pattern_deletion_stack_core_tb.sv
